@@ hdl/crcmx_pkg.sv @@
package crcmx_pkg;

	localparam int WORD_W = 32;
	localparam int BLEN_W = 21;
	localparam int CNT_W = 3;
	localparam int BYTES = 4;
	localparam int LANES = 16;
	localparam int LANE_W = 4;
	localparam int BANKS = 4;
	localparam int BANK_W = 2;
	localparam int BANK_DEPTH = LANES / BANKS;
	localparam int BADDR_W = LANE_W - BANK_W;

	localparam longint unsigned MAX_BLOCK_BYTES = 64'd1048576;

	localparam logic [WORD_W-1:0] CASTAGNOLI_REFL = 32'h82F63B78;
	localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [WORD_W-1:0] GOLDEN = 32'h9E3779B9;
	localparam int ROT_LEFT = 7;
	localparam int XSHIFT = 11;

	localparam logic [LANE_W-1:0] LAST_LANE = 4'd15;

	localparam logic [1:0] KIND_WORD = 2'd0;
	localparam logic [1:0] KIND_LANE = 2'd1;
	localparam logic [1:0] KIND_IN_CRC = 2'd2;
	localparam logic [1:0] KIND_OUT_CRC = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	// which bytes of the item go to which bank, and the row each bank touches
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [BANKS-1:0][BYTES-1:0] byte_mask;
		logic [BANKS-1:0][BADDR_W-1:0] addr;
	} plan_t;

	function automatic word_t crc_byte(input word_t crc, input logic [7:0] b);
		word_t c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CASTAGNOLI_REFL : 32'd0);
		end
		return c;
	endfunction

	function automatic logic [CNT_W-1:0] norm_count(input logic [CNT_W-1:0] c);
		case (c)
			3'd1, 3'd2, 3'd3: return c;
			default: return 3'd4;
		endcase
	endfunction

	function automatic word_t byte_mask(input logic [CNT_W-1:0] c);
		case (c)
			3'd1: return 32'h000000FF;
			3'd2: return 32'h0000FFFF;
			3'd3: return 32'h00FFFFFF;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	function automatic word_t salt(input logic [LANE_W-1:0] idx);
		case (idx)
			4'd0: return 32'h243F6A88;
			4'd1: return 32'h85A308D3;
			4'd2: return 32'h13198A2E;
			4'd3: return 32'h03707344;
			4'd4: return 32'hA4093822;
			4'd5: return 32'h299F31D0;
			4'd6: return 32'h082EFA98;
			4'd7: return 32'hEC4E6C89;
			4'd8: return 32'h452821E6;
			4'd9: return 32'h38D01377;
			4'd10: return 32'hBE5466CF;
			4'd11: return 32'h34E90C6C;
			4'd12: return 32'hC0AC29B7;
			4'd13: return 32'hC97C50DD;
			4'd14: return 32'h3F84D5B5;
			default: return 32'hB5470917;
		endcase
	endfunction

endpackage

@@ hdl/crcmx_in_if.sv @@
interface crcmx_in_if;
	logic valid;
	logic ready;
	logic [31:0] data_word;
	logic [2:0] byte_count;
	logic [20:0] block_bytes;
	logic last;

	modport source (output valid, output data_word, output byte_count, output block_bytes,
		output last, input ready);
	modport sink (input valid, input data_word, input byte_count, input block_bytes,
		input last, output ready);
endinterface

@@ hdl/crcmx_out_if.sv @@
interface crcmx_out_if;
	logic valid;
	logic ready;
	logic [1:0] result_kind;
	logic [3:0] lane_index;
	logic [31:0] result_value;
	logic [2:0] valid_bytes;
	logic end_of_run;

	modport source (output valid, output result_kind, output lane_index, output result_value,
		output valid_bytes, output end_of_run, input ready);
	modport sink (input valid, input result_kind, input lane_index, input result_value,
		input valid_bytes, input end_of_run, output ready);
endinterface

@@ hdl/crcmx_lane_plan.sv @@
module crcmx_lane_plan #(
	parameter longint unsigned MAX_BLOCK_BYTES = crcmx_pkg::MAX_BLOCK_BYTES
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic last,
	input logic [crcmx_pkg::CNT_W-1:0] byte_count,
	input logic [crcmx_pkg::BLEN_W-1:0] block_bytes,
	output crcmx_pkg::plan_t plan,
	output logic [crcmx_pkg::LANE_W-1:0] word_index
);

	localparam longint unsigned BLEN_MAX = (64'd1 << crcmx_pkg::BLEN_W) - 64'd1;
	localparam longint unsigned LEN_CAP =
		(MAX_BLOCK_BYTES < BLEN_MAX) ? MAX_BLOCK_BYTES : BLEN_MAX;
	localparam int LEFT_W = $clog2(LEN_CAP / crcmx_pkg::LANES + 2);
	localparam logic [crcmx_pkg::BLEN_W-1:0] CAP_V = crcmx_pkg::BLEN_W'(LEN_CAP);

	logic in_block_q;
	logic [crcmx_pkg::LANE_W-1:0] lane_q;
	logic [LEFT_W-1:0] left_q;
	logic [LEFT_W-1:0] quot_q;
	logic [crcmx_pkg::LANE_W-1:0] rem_q;
	logic [crcmx_pkg::LANE_W-1:0] word_q;

	logic [crcmx_pkg::BLEN_W-1:0] blen_c;
	logic [LEFT_W-1:0] quot0, quot_e, left_e, left_v;
	logic [crcmx_pkg::LANE_W-1:0] rem0, rem_e, lane_e, lane_v;
	crcmx_pkg::plan_t plan_c;

	assign blen_c = (block_bytes > CAP_V) ? CAP_V : block_bytes;
	assign quot0 = LEFT_W'(blen_c >> crcmx_pkg::LANE_W);
	assign rem0 = blen_c[crcmx_pkg::LANE_W-1:0];

	// a new block starts with lane 0 holding its full share
	assign quot_e = in_block_q ? quot_q : quot0;
	assign rem_e = in_block_q ? rem_q : rem0;
	assign lane_e = in_block_q ? lane_q : '0;
	assign left_e = in_block_q ? left_q : quot0 + LEFT_W'(rem0 != '0);

	always_comb begin
		plan_c = '0;
		plan_c.cnt = crcmx_pkg::norm_count(byte_count);
		lane_v = lane_e;
		left_v = left_e;
		for (int j = 0; j < crcmx_pkg::BYTES; j++) begin
			if (crcmx_pkg::CNT_W'(j) < plan_c.cnt) begin
				// step past an empty lane; with under 16 bytes the empty ones are all at the end
				if (left_v == '0 && lane_v != crcmx_pkg::LAST_LANE) begin
					if (quot_e != '0) begin
						lane_v = lane_v + 4'd1;
						left_v = quot_e + LEFT_W'(lane_v < rem_e);
					end else if ((lane_v + 4'd1) < rem_e) begin
						lane_v = lane_v + 4'd1;
						left_v = LEFT_W'(1);
					end else begin
						lane_v = crcmx_pkg::LAST_LANE;
						left_v = '0;
					end
				end
				if (left_v != '0) begin
					plan_c.byte_mask[lane_v[crcmx_pkg::BANK_W-1:0]][j] = 1'b1;
					plan_c.addr[lane_v[crcmx_pkg::BANK_W-1:0]] =
						lane_v[crcmx_pkg::LANE_W-1:crcmx_pkg::BANK_W];
					left_v = left_v - LEFT_W'(1);
				end
			end
		end
	end

	assign plan = plan_c;
	assign word_index = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_block_q <= 1'b0;
			lane_q <= '0;
			left_q <= '0;
			quot_q <= '0;
			rem_q <= '0;
			word_q <= '0;
		end else if (accept) begin
			if (last) begin
				in_block_q <= 1'b0;
				lane_q <= '0;
				left_q <= '0;
				quot_q <= '0;
				rem_q <= '0;
				word_q <= '0;
			end else begin
				in_block_q <= 1'b1;
				lane_q <= lane_v;
				left_q <= left_v;
				quot_q <= quot_e;
				rem_q <= rem_e;
				word_q <= word_q + 4'd1;
			end
		end
	end

endmodule

@@ hdl/crcmx_mixer.sv @@
module crcmx_mixer (
	input logic clk,
	input logic load,
	input crcmx_pkg::word_t data_word,
	input logic [crcmx_pkg::LANE_W-1:0] word_index,
	output crcmx_pkg::word_t mixed
);

	crcmx_pkg::word_t prod_s1;
	crcmx_pkg::word_t salted;
	crcmx_pkg::word_t rot;

	assign salted = data_word ^ crcmx_pkg::salt(word_index);

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= salted * crcmx_pkg::GOLDEN;
		end
	end

	assign rot = {prod_s1[crcmx_pkg::WORD_W-crcmx_pkg::ROT_LEFT-1:0],
		prod_s1[crcmx_pkg::WORD_W-1:crcmx_pkg::WORD_W-crcmx_pkg::ROT_LEFT]};
	assign mixed = rot ^ (rot >> crcmx_pkg::XSHIFT);

endmodule

@@ hdl/crcmx_lane_ram.sv @@
module crcmx_lane_ram (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [crcmx_pkg::BANKS-1:0][crcmx_pkg::BADDR_W-1:0] rd_addr,
	input logic [crcmx_pkg::BANKS-1:0] wr_en,
	input logic [crcmx_pkg::BANKS-1:0][crcmx_pkg::BADDR_W-1:0] wr_addr,
	input logic [crcmx_pkg::BANKS-1:0][crcmx_pkg::WORD_W-1:0] wr_data,
	input logic clr,
	output logic [crcmx_pkg::BANKS-1:0][crcmx_pkg::WORD_W-1:0] rd_data
);

	// lane k lives in bank k mod 4, so four consecutive lanes never collide
	for (genvar b = 0; b < crcmx_pkg::BANKS; b++) begin : g_bank
		crcmx_pkg::word_t mem [crcmx_pkg::BANK_DEPTH];
		logic [crcmx_pkg::BANK_DEPTH-1:0] vld_q;
		crcmx_pkg::word_t rd_q;

		always_ff @(posedge clk) begin
			if (wr_en[b]) begin
				mem[wr_addr[b]] <= wr_data[b];
			end
		end

		// forward a write landing in the same cycle; unwritten rows read as the crc seed
		always_ff @(posedge clk) begin
			if (rd_en) begin
				if (wr_en[b] && wr_addr[b] == rd_addr[b]) begin
					rd_q <= wr_data[b];
				end else if (vld_q[rd_addr[b]]) begin
					rd_q <= mem[rd_addr[b]];
				end else begin
					rd_q <= crcmx_pkg::CRC_INIT;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= '0;
			end else if (clr) begin
				vld_q <= '0;
			end else if (wr_en[b]) begin
				vld_q[wr_addr[b]] <= 1'b1;
			end
		end

		assign rd_data[b] = rd_q;
	end

endmodule

@@ hdl/block_crc32c_lane_mixer_core.sv @@
// crc32c lane mixer
// feed channel: one item per word of a block, little-endian, byte_count valid bytes,
// block_bytes read on the first item of a block, last on its final word.
// result channel: one data word per item, mixed if all four bytes are valid; after
// the last word, the 16 lane crcs in lane order, then the crc over the input bytes,
// then the crc over the mixed bytes, which carries end_of_run.
// each word goes through the update stage and then the output register.
// throughput: one item per cycle inside a block while results are taken. the lane
// crcs sit in a 4-bank ram read as each item is taken, ahead of the update stage,
// with a bypass for back-to-back items on the same lane. closing a block emits 18
// results, with one ram read first to prime them; feed is held off from the last
// word until the final crc is loaded into the output register.
// reset clears all control state and the lane valid bits at once; no clearing pass.
// a stalled result holds in the output register; the update stage still takes one
// more item behind it, then feed.ready drops until the result is taken.
module block_crc32c_lane_mixer_core #(
	parameter longint unsigned MAX_BLOCK_BYTES = crcmx_pkg::MAX_BLOCK_BYTES
) (
	input logic clk,
	input logic arst_n,
	crcmx_in_if.sink feed,
	crcmx_out_if.source result
);

	localparam logic [4:0] TAIL_IN_IDX = 5'd16;
	localparam logic [4:0] TAIL_OUT_IDX = 5'd17;
	localparam logic [4:0] TAIL_LAST_LANE = 5'd15;

	logic accept;
	logic out_free;
	logic s1_fire;
	logic in_ready;

	crcmx_pkg::plan_t plan;
	logic [crcmx_pkg::LANE_W-1:0] word_index;
	crcmx_pkg::word_t mix_out;

	logic s1_valid_q;
	logic s1_last_q;
	crcmx_pkg::plan_t plan_s1;
	crcmx_pkg::word_t data_s1;

	crcmx_pkg::word_t in_crc_q, out_crc_q;
	crcmx_pkg::word_t in_crc_n, out_crc_n, mixed;

	logic tail_active_q;
	logic tail_have_q;
	logic [4:0] tail_idx_q;
	logic tail_emit, tail_rd, tail_done;
	logic [crcmx_pkg::LANE_W-1:0] tail_lane;

	logic rd_en;
	logic [crcmx_pkg::BANKS-1:0][crcmx_pkg::BADDR_W-1:0] rd_addr;
	logic [crcmx_pkg::BANKS-1:0] wr_en;
	logic [crcmx_pkg::BANKS-1:0][crcmx_pkg::WORD_W-1:0] wr_data;
	logic [crcmx_pkg::BANKS-1:0][crcmx_pkg::WORD_W-1:0] rd_data;

	logic out_valid_q;
	logic [1:0] kind_q;
	logic [crcmx_pkg::LANE_W-1:0] lane_idx_q;
	crcmx_pkg::word_t value_q;
	logic [crcmx_pkg::CNT_W-1:0] vbytes_q;
	logic eor_q;

	assign out_free = !out_valid_q || result.ready;
	assign s1_fire = s1_valid_q && out_free;
	assign in_ready = !tail_active_q && (!s1_valid_q || (!s1_last_q && out_free));
	assign feed.ready = in_ready;
	assign accept = feed.valid && in_ready;

	crcmx_lane_plan #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_plan (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.last(feed.last),
		.byte_count(feed.byte_count),
		.block_bytes(feed.block_bytes),
		.plan(plan),
		.word_index(word_index)
	);

	crcmx_mixer u_mixer (
		.clk(clk),
		.load(accept),
		.data_word(feed.data_word),
		.word_index(word_index),
		.mixed(mix_out)
	);

	// update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_last_q <= feed.last;
			plan_s1 <= plan;
			data_s1 <= feed.data_word & crcmx_pkg::byte_mask(plan.cnt);
		end
	end

	// short words pass through unmixed
	assign mixed = (plan_s1.cnt == 3'd4) ? mix_out : data_s1;

	always_comb begin
		in_crc_n = in_crc_q;
		out_crc_n = out_crc_q;
		for (int j = 0; j < crcmx_pkg::BYTES; j++) begin
			if (crcmx_pkg::CNT_W'(j) < plan_s1.cnt) begin
				in_crc_n = crcmx_pkg::crc_byte(in_crc_n, data_s1[8*j +: 8]);
				out_crc_n = crcmx_pkg::crc_byte(out_crc_n, mixed[8*j +: 8]);
			end
		end
	end

	always_comb begin
		for (int b = 0; b < crcmx_pkg::BANKS; b++) begin
			wr_data[b] = rd_data[b];
			for (int j = 0; j < crcmx_pkg::BYTES; j++) begin
				if (plan_s1.byte_mask[b][j]) begin
					wr_data[b] = crcmx_pkg::crc_byte(wr_data[b], data_s1[8*j +: 8]);
				end
			end
			wr_en[b] = s1_fire && (plan_s1.byte_mask[b] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_crc_q <= crcmx_pkg::CRC_INIT;
			out_crc_q <= crcmx_pkg::CRC_INIT;
		end else if (tail_done) begin
			in_crc_q <= crcmx_pkg::CRC_INIT;
			out_crc_q <= crcmx_pkg::CRC_INIT;
		end else if (s1_fire) begin
			in_crc_q <= in_crc_n;
			out_crc_q <= out_crc_n;
		end
	end

	// end of block: read lane crcs one ahead of the result register
	assign tail_emit = tail_active_q && out_free && (tail_have_q || tail_idx_q[4]);
	assign tail_done = tail_emit && tail_idx_q == TAIL_OUT_IDX;
	assign tail_rd = tail_active_q && !tail_idx_q[4]
		&& (!tail_have_q || (tail_emit && tail_idx_q != TAIL_LAST_LANE));
	assign tail_lane = tail_have_q ? tail_idx_q[3:0] + 4'd1 : tail_idx_q[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_active_q <= 1'b0;
			tail_have_q <= 1'b0;
			tail_idx_q <= '0;
		end else if (s1_fire && s1_last_q) begin
			tail_active_q <= 1'b1;
			tail_have_q <= 1'b0;
			tail_idx_q <= '0;
		end else if (tail_active_q) begin
			if (tail_emit) begin
				tail_idx_q <= tail_idx_q + 5'd1;
				tail_have_q <= tail_rd;
				if (tail_done) begin
					tail_active_q <= 1'b0;
				end
			end else if (tail_rd) begin
				tail_have_q <= 1'b1;
			end
		end
	end

	always_comb begin
		rd_en = accept || tail_rd;
		for (int b = 0; b < crcmx_pkg::BANKS; b++) begin
			rd_addr[b] = accept ? plan.addr[b]
				: tail_lane[crcmx_pkg::LANE_W-1:crcmx_pkg::BANK_W];
		end
	end

	crcmx_lane_ram u_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.wr_en(wr_en),
		.wr_addr(plan_s1.addr),
		.wr_data(wr_data),
		.clr(tail_done),
		.rd_data(rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire || tail_emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			kind_q <= crcmx_pkg::KIND_WORD;
			lane_idx_q <= '0;
			value_q <= mixed;
			vbytes_q <= plan_s1.cnt;
			eor_q <= 1'b0;
		end else if (tail_emit) begin
			vbytes_q <= '0;
			if (!tail_idx_q[4]) begin
				kind_q <= crcmx_pkg::KIND_LANE;
				lane_idx_q <= tail_idx_q[3:0];
				value_q <= ~rd_data[tail_idx_q[crcmx_pkg::BANK_W-1:0]];
				eor_q <= 1'b0;
			end else if (tail_idx_q == TAIL_IN_IDX) begin
				kind_q <= crcmx_pkg::KIND_IN_CRC;
				lane_idx_q <= '0;
				value_q <= ~in_crc_q;
				eor_q <= 1'b0;
			end else begin
				kind_q <= crcmx_pkg::KIND_OUT_CRC;
				lane_idx_q <= '0;
				value_q <= ~out_crc_q;
				eor_q <= 1'b1;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.result_kind = kind_q;
	assign result.lane_index = lane_idx_q;
	assign result.result_value = value_q;
	assign result.valid_bytes = vbytes_q;
	assign result.end_of_run = eor_q;

endmodule

@@ tb/tb_block_crc32c_lane_mixer_core.sv @@
module tb_block_crc32c_lane_mixer_core;

	localparam int ITEM_TARGET = 120;
	localparam int CALM_AT = ITEM_TARGET - 25;
	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_LIMIT = 1000;
	localparam int TAIL_CYCLES = 8;

	localparam logic [31:0] SALTS [16] = '{
		32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
		32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
		32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
		32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] lane;
		logic [31:0] value;
		logic [2:0] vbytes;
		logic eor;
	} result_t;

	class mixer_tracker_t;
		result_t pending_results[$];
		int errors;
		logic [20:0] pos;
		logic [3:0] word_idx;
		logic [31:0] crc_in;
		logic [31:0] crc_out;
		logic [31:0] lane_crc [16];
		int unsigned lane_at;
		int unsigned lane_owed;
		int unsigned blen;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			pos = '0;
			word_idx = '0;
			crc_in = '1;
			crc_out = '1;
			foreach (lane_crc[k]) lane_crc[k] = '1;
			lane_at = 0;
			lane_owed = 0;
			blen = 0;
		endfunction

		function logic [31:0] crc32c_step(input logic [31:0] c, input logic [7:0] b);
			logic [31:0] r;
			r = c ^ {24'd0, b};
			for (int k = 0; k < 8; k++) begin
				r = r[0] ? ((r >> 1) ^ crcmx_pkg::CASTAGNOLI_REFL) : (r >> 1);
			end
			return r;
		endfunction

		function int unsigned lane_len(input int unsigned k);
			return blen / crcmx_pkg::LANES + ((k < blen % crcmx_pkg::LANES) ? 1 : 0);
		endfunction

		function logic [31:0] mix32(input logic [31:0] w, input logic [3:0] idx);
			logic [31:0] x;
			x = (w ^ SALTS[idx]) * crcmx_pkg::GOLDEN;
			x = {x[24:0], x[31:25]};
			return x ^ (x >> 11);
		endfunction

		// empty lanes are skipped; bytes past lane 15 go nowhere
		function void lane_push(input logic [7:0] b);
			while (lane_owed == 0 && lane_at < crcmx_pkg::LANES - 1) begin
				lane_at++;
				lane_owed = lane_len(lane_at);
			end
			if (lane_owed > 0) begin
				lane_crc[lane_at] = crc32c_step(lane_crc[lane_at], b);
				lane_owed--;
			end
		endfunction

		function void take_word(input logic [31:0] data, input logic [2:0] cnt_raw,
				input logic [20:0] blen_raw, input logic last);
			int unsigned n;
			logic [31:0] src;
			logic [31:0] mixed;
			n = (cnt_raw == 0 || cnt_raw > 4) ? 4 : 32'(cnt_raw);
			if (pos == 0) begin
				if (blen_raw > crcmx_pkg::MAX_BLOCK_BYTES) blen = 32'(crcmx_pkg::MAX_BLOCK_BYTES);
				else blen = 32'(blen_raw);
				lane_at = 0;
				lane_owed = lane_len(0);
			end
			if (n == 4) begin
				src = data;
				mixed = mix32(data, word_idx);
			end else begin
				src = data & ((32'd1 << (8 * n)) - 32'd1);
				mixed = src;
			end
			for (int k = 0; k < n; k++) begin
				crc_in = crc32c_step(crc_in, src[8*k +: 8]);
				crc_out = crc32c_step(crc_out, mixed[8*k +: 8]);
				lane_push(src[8*k +: 8]);
			end
			if (int'(pos) + n > 32'h1FFFFF) pos = '1;
			else pos = pos + 21'(n);
			word_idx = word_idx + 4'd1;
			pending_results.push_back('{crcmx_pkg::KIND_WORD, 4'd0, mixed, 3'(n), 1'b0});
			if (last) begin
				for (int k = 0; k < crcmx_pkg::LANES; k++) begin
					pending_results.push_back('{crcmx_pkg::KIND_LANE, 4'(k), ~lane_crc[k],
						3'd0, 1'b0});
				end
				pending_results.push_back('{crcmx_pkg::KIND_IN_CRC, 4'd0, ~crc_in, 3'd0, 1'b0});
				pending_results.push_back('{crcmx_pkg::KIND_OUT_CRC, 4'd0, ~crc_out, 3'd0,
					1'b1});
				restart();
			end
		endfunction

		function void report(input string field, input logic [31:0] want,
				input logic [31:0] got);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		endfunction

		function void match_result(input result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d value %h",
					$time, got.kind, got.value);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind)
				report("result_kind", 32'(want.kind), 32'(got.kind));
			if (got.lane !== want.lane)
				report("lane_index", 32'(want.lane), 32'(got.lane));
			if (got.value !== want.value)
				report("result_value", want.value, got.value);
			if (got.vbytes !== want.vbytes)
				report("valid_bytes", 32'(want.vbytes), 32'(got.vbytes));
			if (got.eor !== want.eor)
				report("end_of_run", 32'(want.eor), 32'(got.eor));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	mixer_tracker_t board;
	int items_sent;
	bit calm;
	bit hold_req;
	int hold_left;
	int stall_left;

	crcmx_in_if feed();
	crcmx_out_if result();

	block_crc32c_lane_mixer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed),
		.result(result)
	);

	always #6 clk = ~clk;

	// result side: check accepted items, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				board.match_result('{result.result_kind, result.lane_index, result.result_value,
					result.valid_bytes, result.end_of_run});
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				result.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((feed.valid && feed.ready) || (result.valid && result.ready)) idle = 0;
			else idle++;
		end
		$display("tb_block_crc32c_lane_mixer_core: errors");
		$finish;
	end

	task automatic send_item(input logic [31:0] d, input logic [2:0] c,
			input logic [20:0] b, input logic l);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			feed.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed.valid <= 1'b1;
		feed.data_word <= d;
		feed.byte_count <= c;
		feed.block_bytes <= b;
		feed.last <= l;
		@(posedge clk);
		while (!feed.ready) @(posedge clk);
		board.take_word(d, c, b, l);
		items_sent++;
		if (items_sent >= CALM_AT) calm = 1'b1;
	endtask

	// block_bytes only matters on the first item, so later items carry junk there
	task automatic send_block(input int nbytes, input logic [20:0] declared, input bit noisy);
		int words;
		int c;
		logic [20:0] b;
		words = (nbytes + 3) / 4;
		for (int i = 0; i < words; i++) begin
			c = (i == words - 1) ? nbytes - 4 * i : 4;
			if (noisy && $urandom_range(0, 5) == 0) c = $urandom_range(0, 7);
			b = (i == 0) ? declared : 21'($urandom);
			send_item($urandom, 3'(c), b, i == words - 1);
		end
	endtask

	task automatic drain();
		feed.valid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		int pick;
		int nbytes;
		board = new();
		items_sent = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		stall_left = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		feed.valid = 1'b0;
		feed.data_word = '0;
		feed.byte_count = '0;
		feed.block_bytes = '0;
		feed.last = 1'b0;
		result.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// single byte block
		send_item(32'hFFFFFFFF, 3'd1, 21'd1, 1'b1);
		// counts of zero and above four act as full words
		send_item(32'h00000000, 3'd0, 21'd16, 1'b0);
		send_item(32'hFFFFFFFF, 3'd5, 21'd16, 1'b0);
		send_item(32'hA5A5A5A5, 3'd6, 21'd16, 1'b0);
		send_item(32'h5A5A5A5A, 3'd7, 21'd16, 1'b1);
		// declared length over the limit, block ends early
		send_item($urandom, 3'd4, 21'h1FFFFF, 1'b0);
		send_item($urandom, 3'd3, 21'h000000, 1'b1);
		// zero length: every byte misses the lanes
		send_item($urandom, 3'd4, 21'd0, 1'b0);
		send_item($urandom, 3'd2, 21'h1FFFFF, 1'b1);
		// more bytes than declared
		send_item($urandom, 3'd4, 21'd3, 1'b0);
		send_item($urandom, 3'd4, 21'($urandom), 1'b0);
		send_item($urandom, 3'd1, 21'($urandom), 1'b1);
		// short word ahead of the last one
		send_item($urandom, 3'd2, 21'd10, 1'b0);
		send_item($urandom, 3'd4, 21'($urandom), 1'b0);
		send_item($urandom, 3'd4, 21'($urandom), 1'b1);
		// largest legal length
		send_item($urandom, 3'd4, 21'(crcmx_pkg::MAX_BLOCK_BYTES), 1'b0);
		send_item($urandom, 3'd3, 21'($urandom), 1'b1);
		drain();

		// long result stall while a block keeps coming
		hold_req = 1'b1;
		send_block(120, 21'd120, 1'b0);

		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				nbytes = $urandom_range(1, 40);
				send_block(nbytes, $urandom_range(0, 1) ? 21'($urandom) :
					21'(nbytes + $urandom_range(0, 8) - 4), 1'b1);
			end else if (pick == 1) begin
				nbytes = $urandom_range(101, 200);
				send_block(nbytes, 21'(nbytes), 1'b0);
			end else begin
				nbytes = $urandom_range(1, 100);
				send_block(nbytes, 21'(nbytes), 1'b0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0) begin
			$display("tb_block_crc32c_lane_mixer_core: clean");
		end else begin
			$display("tb_block_crc32c_lane_mixer_core: errors");
		end
		$finish;
	end

endmodule
